>>> hw/rtl/dpc_pkg.sv
// Package for the decimal product by convolution block.
// Holds sizes, the mode and state codes, and the run length helper.
// Depends on nothing; used by decimal_product_by_convolution.
`default_nettype none

package dpc_pkg;

  // Vector sizes.
  localparam int MAX_LEN = 32;
  localparam int ELEM_W  = 16;
  localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);

  // Field widths of the result word.
  localparam int DIGIT_W = 4;
  localparam int POS_W   = 6;

  // Column arithmetic.
  localparam int PROD_W = 2 * ELEM_W;
  localparam int SUM_W  = 40;
  localparam int TOT_W  = SUM_W + 1;
  localparam int RADIX  = 10;

  // Divide by ten: sixteen bits a step, most significant chunk first. The
  // remainder and one chunk stay below 2^22, where the reciprocal multiply
  // by ceil(2^23 / 10) followed by a shift of 23 gives the exact quotient.
  localparam int DIV_CHUNK_W = 16;
  localparam int DIV_STEPS   = 3;
  localparam int DIV_W       = DIV_STEPS * DIV_CHUNK_W;
  localparam int DIV_V_W     = DIGIT_W + DIV_CHUNK_W;
  localparam int RECIP_SHIFT = 23;
  localparam logic [DIV_V_W-1:0] RECIP_TEN = DIV_V_W'((1 << RECIP_SHIFT) / RADIX + 1);

  // Sequencer step counts.
  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam logic [CNT_W-1:0] DRAIN_LAST = CNT_W'(1);
  localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(DIV_STEPS - 1);

  typedef enum logic [1:0] {
    MODE_LOAD_A  = 2'd0,
    MODE_LOAD_B  = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Highest digit position of a run: the smallest power of two that is at
  // least the combined length, minus one. A total of zero or one gives zero.
  function automatic logic [POS_W-1:0] run_last(input logic [POS_W:0] total);
    logic [POS_W:0]   p;
    logic [POS_W-1:0] r;
    r = '0;
    for (int j = POS_W; j >= 0; j--) begin
      p = (POS_W + 1)'(1) << j;
      if (p >= total) begin
        r = POS_W'(p - (POS_W + 1)'(1));
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/decimal_product_by_convolution.sv
// Top level of the decimal product by convolution block.
// Holds both operand stores, the shared multiply-accumulate and a chunked
// reciprocal divide by ten under one sequencer. Depends on dpc_pkg.
`default_nettype none

// A load word (mode 0 for A, mode 1 for B) appends one element; loads past
// MAX_LEN are dropped and mode 3 is ignored. A compute word (mode 2) produces
// n digits, n being the smallest power of two at least len_a + len_b (one
// when both are empty), least significant first, with last set on digit
// n-1. Each column steps every index of A (at least one) through the single
// 16x16 multiplier and the accumulator, drains the pipeline, adds the carry
// and runs the divide by ten, which takes sixteen bits a cycle by reciprocal
// multiplication, then holds its digit until taken. The block takes no word
// while a compute is running; both lengths are cleared once the last digit
// is taken.
module decimal_product_by_convolution
  import dpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  wire logic [1:0]         mode,
  input  wire logic [15:0]        element_value,
  output logic                    result_valid,
  input  wire logic               result_ready,
  output logic [DIGIT_W-1:0]      digit,
  output logic [POS_W-1:0]        position,
  output logic                    last
);

  state_t state, state_next;

  // Operand stores and their registered read data.
  logic [ELEM_W-1:0] store_a [MAX_LEN];
  logic [ELEM_W-1:0] store_b [MAX_LEN];
  logic [ELEM_W-1:0] a_q, b_q;

  logic [LEN_W-1:0]  len_a, len_b;
  logic [LEN_W-1:0]  idx;
  logic [POS_W-1:0]  k;
  logic [POS_W-1:0]  n_last;
  logic [CNT_W-1:0]  cnt;

  // Multiply-accumulate pipeline.
  logic              v1, v2;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  acc;
  logic [SUM_W-1:0]  carry;

  // Divide by ten.
  logic [DIV_W-1:0]       total;
  logic [DIGIT_W-1:0]     rem;
  logic [DIV_V_W-1:0]     div_v;
  logic [2*DIV_V_W-1:0]   div_prod;
  logic [DIV_CHUNK_W-1:0] div_q;
  logic [DIGIT_W-1:0]     rem_next;
  logic [DIV_W-1:0]       total_next;

  logic [ELEM_W-1:0] load_val;
  logic              wr_a, wr_b, start;
  logic [POS_W:0]    b_diff;
  logic              term_ok;
  logic              mac_done;

  // Input decode.
  assign item_ready = (state == ST_IDLE);
  assign load_val   = element_value[ELEM_W-1:0];

  always_comb begin
    wr_a  = 1'b0;
    wr_b  = 1'b0;
    start = 1'b0;
    if (item_valid && item_ready) begin
      unique case (mode_t'(mode))
        MODE_LOAD_A:  wr_a  = (len_a < LEN_W'(MAX_LEN));
        MODE_LOAD_B:  wr_b  = (len_b < LEN_W'(MAX_LEN));
        MODE_COMPUTE: start = 1'b1;
        default:      ;
      endcase
    end
  end

  // A term of column k pairs a[idx] with b[k - idx] when both are loaded.
  assign b_diff   = {1'b0, k} - (POS_W + 1)'(idx);
  assign term_ok  = (idx < len_a) && ((POS_W + 1)'(idx) <= {1'b0, k}) &&
                    (b_diff < (POS_W + 1)'(len_b));
  assign mac_done = ({1'b0, idx} + (LEN_W + 1)'(1)) >= {1'b0, len_a};

  // One step of the divide by ten: the running remainder and the next chunk
  // are divided by a reciprocal multiply, and the new remainder comes back
  // from subtracting ten times the chunk quotient.
  assign div_v      = {rem, total[DIV_W-1 -: DIV_CHUNK_W]};
  assign div_prod   = (2 * DIV_V_W)'(div_v) * (2 * DIV_V_W)'(RECIP_TEN);
  assign div_q      = div_prod[RECIP_SHIFT +: DIV_CHUNK_W];
  assign rem_next   = DIGIT_W'(div_v - ((DIV_V_W'(div_q) << 3) + (DIV_V_W'(div_q) << 1)));
  assign total_next = {total[DIV_W-DIV_CHUNK_W-1:0], div_q};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_MAC;
      ST_MAC:   if (mac_done) state_next = ST_DRAIN;
      ST_DRAIN: if (cnt == DRAIN_LAST) state_next = ST_SUM;
      ST_SUM:   state_next = ST_DIV;
      ST_DIV:   if (cnt == DIV_LAST) state_next = ST_EMIT;
      ST_EMIT:  if (result_ready) state_next = last ? ST_IDLE : ST_MAC;
      default:  state_next = ST_IDLE;
    endcase
  end

  assign result_valid = (state == ST_EMIT);

  // Operand stores: write on load, registered read for the current term.
  always_ff @(posedge clk) begin
    if (wr_a) begin
      store_a[len_a[ADDR_W-1:0]] <= load_val;
    end
    if (wr_b) begin
      store_b[len_b[ADDR_W-1:0]] <= load_val;
    end
    a_q <= store_a[idx[ADDR_W-1:0]];
    b_q <= store_b[b_diff[ADDR_W-1:0]];
  end

  // Control registers: lengths and pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      len_a <= '0;
      len_b <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
    end else begin
      v1 <= (state == ST_MAC) && term_ok;
      v2 <= v1;
      if (wr_a) begin
        len_a <= len_a + LEN_W'(1);
      end
      if (wr_b) begin
        len_b <= len_b + LEN_W'(1);
      end
      if (result_valid && result_ready && last) begin
        len_a <= '0;
        len_b <= '0;
      end
    end
  end

  // Datapath: multiply, accumulate, carry add, divide, result word.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(a_q) * PROD_W'(b_q);
    if (v2) begin
      acc <= acc + SUM_W'(prod);
    end
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          k      <= '0;
          idx    <= '0;
          acc    <= '0;
          carry  <= '0;
          n_last <= run_last((POS_W + 1)'(len_a) + (POS_W + 1)'(len_b));
        end
      end
      ST_MAC: begin
        idx <= idx + LEN_W'(1);
        cnt <= '0;
      end
      ST_DRAIN: begin
        cnt <= cnt + CNT_W'(1);
      end
      ST_SUM: begin
        total <= {{(DIV_W - TOT_W){1'b0}}, {1'b0, acc} + {1'b0, carry}};
        rem   <= '0;
        cnt   <= '0;
      end
      ST_DIV: begin
        total <= total_next;
        rem   <= rem_next;
        cnt   <= cnt + CNT_W'(1);
        if (cnt == DIV_LAST) begin
          digit    <= rem_next;
          position <= k;
          last     <= (k == n_last);
          carry    <= total_next[SUM_W-1:0];
        end
      end
      ST_EMIT: begin
        if (result_ready && !last) begin
          k   <= k + POS_W'(1);
          idx <= '0;
          acc <= '0;
        end
      end
      default: ;
    endcase
  end

  // The block never takes a word while a digit is waiting.
  assert property (@(posedge clk) disable iff (rst) !(item_ready && result_valid))
    else $error("input taken while a digit is pending");

  // Every digit is a decimal digit.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (digit < DIGIT_W'(RADIX)))
    else $error("digit out of decimal range");

  // No digit beyond the run length.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (position <= n_last))
    else $error("digit position beyond run length");

  // Taking the final digit clears both lengths.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && last) |=> (len_a == '0 && len_b == '0))
    else $error("lengths not cleared after final digit");

endmodule

`default_nettype wire
